>>> rtl/core/pptc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pptc_pkg
// Shared types and constants of the position PID thrust controller.
// ---------------------------------------------------------------------------
package pptc_pkg;

  localparam int THRUST_HI    = 160;
  localparam int THRUST_LO    = 66;
  localparam int WINDUP_LIMIT = 40;
  localparam int POS_MIN      = -65536;
  localparam int POS_MAX      = 131071;
  localparam int DIV_STEPS    = 32;
  localparam int DIV_CNT_W    = $clog2(DIV_STEPS);
  localparam int CFG_IDX_W    = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SETPOINT      = 4'd0,
    REG_TRAVEL_LENGTH = 4'd1,
    REG_KP            = 4'd2,
    REG_KI_SCALED     = 4'd3,
    REG_KD_SCALED     = 4'd4,
    REG_BIAS          = 4'd5,
    REG_LOW_CODE      = 4'd6,
    REG_HIGH_CODE     = 4'd7
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] setpoint;
    logic [15:0] travel_length;
    logic [15:0] kp;
    logic [15:0] ki_scaled;
    logic [15:0] kd_scaled;
    logic [15:0] bias;
    logic [15:0] low_code;
    logic [15:0] high_code;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_POS,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_POS,
    OP_ERR,
    OP_MUL_P,
    OP_MUL_D,
    OP_PD,
    OP_SUM,
    OP_MUL_I,
    OP_TOTAL,
    OP_OUT
  } dp_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_POS,
    S_DIV_INIT,
    S_DIV,
    S_POS,
    S_ERR,
    S_MUL_P,
    S_MUL_D,
    S_PD,
    S_SUM,
    S_MUL_I,
    S_TOTAL,
    S_OUT
  } state_t;

  typedef struct packed {
    dp_op_t op;
  } dp_ctrl_t;

  typedef struct packed {
    logic div_last;
    logic out_stall;
  } dp_stat_t;

endpackage

>>> rtl/core/pptc_regs.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pptc_regs
// Configuration register file, written through the cfg channel.
// ---------------------------------------------------------------------------
module pptc_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pptc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data,
  output pptc_pkg::cfg_t                cfg
);
  import pptc_pkg::*;

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.setpoint      <= 16'd10240;
      cfg_r.travel_length <= 16'd17152;
      cfg_r.kp            <= 16'd11878;
      cfg_r.ki_scaled     <= 16'd307;
      cfg_r.kd_scaled     <= 16'd328;
      cfg_r.bias          <= 16'd23040;
      cfg_r.low_code      <= 16'd0;
      cfg_r.high_code     <= 16'd65535;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SETPOINT:      cfg_r.setpoint      <= cfg_data;
        REG_TRAVEL_LENGTH: cfg_r.travel_length <= cfg_data;
        REG_KP:            cfg_r.kp            <= cfg_data;
        REG_KI_SCALED:     cfg_r.ki_scaled     <= cfg_data;
        REG_KD_SCALED:     cfg_r.kd_scaled     <= cfg_data;
        REG_BIAS:          cfg_r.bias          <= cfg_data;
        REG_LOW_CODE:      cfg_r.low_code      <= cfg_data;
        REG_HIGH_CODE:     cfg_r.high_code     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

>>> rtl/core/pptc_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pptc_ctrl
// Sequencer that steps the datapath through one control tick.
// ---------------------------------------------------------------------------
module pptc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  pptc_pkg::dp_stat_t  stat,
  output pptc_pkg::dp_ctrl_t  ctrl
);
  import pptc_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctrl.op   = OP_NONE;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          ctrl.op   = OP_LOAD;
          state_nxt = S_MUL_POS;
        end
      end
      S_MUL_POS: begin
        ctrl.op   = OP_MUL_POS;
        state_nxt = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        ctrl.op   = OP_DIV_INIT;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        ctrl.op = OP_DIV_STEP;
        if (stat.div_last) begin
          state_nxt = S_POS;
        end
      end
      S_POS: begin
        ctrl.op   = OP_POS;
        state_nxt = S_ERR;
      end
      S_ERR: begin
        ctrl.op   = OP_ERR;
        state_nxt = S_MUL_P;
      end
      S_MUL_P: begin
        ctrl.op   = OP_MUL_P;
        state_nxt = S_MUL_D;
      end
      S_MUL_D: begin
        ctrl.op   = OP_MUL_D;
        state_nxt = S_PD;
      end
      S_PD: begin
        ctrl.op   = OP_PD;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        ctrl.op   = OP_SUM;
        state_nxt = S_MUL_I;
      end
      S_MUL_I: begin
        ctrl.op   = OP_MUL_I;
        state_nxt = S_TOTAL;
      end
      S_TOTAL: begin
        ctrl.op   = OP_TOTAL;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        ctrl.op = OP_OUT;
        if (!stat.out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/pptc_dp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pptc_dp
// Datapath: shared multiplier, radix-2 divider, PID terms and output register.
// ---------------------------------------------------------------------------
module pptc_dp #(
  parameter int SAMPLE_BITS    = 16,
  parameter int GAIN_FRAC_BITS = 12
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pptc_pkg::cfg_t      cfg,
  input  pptc_pkg::dp_ctrl_t  ctrl,
  output pptc_pkg::dp_stat_t  stat,
  input  logic [15:0]         in_tdata,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [39:0]         out_tdata
);
  import pptc_pkg::*;

  localparam int          CODE_BITS = (SAMPLE_BITS < 16) ? SAMPLE_BITS : 16;
  localparam logic [15:0] CODE_MASK = 16'((17'd1 << CODE_BITS) - 17'd1);
  localparam int          PROD_W    = 50;
  localparam int          BIAS_W    = 17 + GAIN_FRAC_BITS;
  localparam int          TOT_W     = ((PROD_W > BIAS_W) ? PROD_W : BIAS_W) + 2;

  localparam logic signed [36:0] WIN_LIM =
    37'(WINDUP_LIMIT * 256) << GAIN_FRAC_BITS;
  localparam logic signed [TOT_W-1:0] THR_HI_FULL =
    TOT_W'(THRUST_HI * 256) << GAIN_FRAC_BITS;
  localparam logic signed [TOT_W-1:0] THR_LO_FULL =
    TOT_W'(THRUST_LO * 256) << GAIN_FRAC_BITS;
  localparam logic signed [31:0] SUM_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SUM_MIN = 32'sh8000_0000;

  logic signed [16:0]        diff_r;
  logic signed [16:0]        den_r;
  logic                      fault_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic [31:0]               quo_r;
  logic [15:0]               rem_r;
  logic [15:0]               den_mag_r;
  logic                      neg_r;
  logic [DIV_CNT_W-1:0]      div_cnt_r;
  logic signed [17:0]        pos_r;
  logic signed [17:0]        err_r;
  logic signed [18:0]        derr_r;
  logic signed [34:0]        pterm_r;
  logic signed [36:0]        pd_r;
  logic                      hold_r;
  logic signed [17:0]        last_error_r;
  logic signed [31:0]        error_sum_r;
  logic signed [TOT_W-1:0]   total_r;
  logic                      out_tvalid_r;
  logic [39:0]               out_tdata_r;

  logic [15:0]               s_m;
  logic [15:0]               lo_m;
  logic [15:0]               hi_m;
  logic signed [16:0]        mul_a;
  logic signed [32:0]        mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic signed [33:0]        num_abs;
  logic signed [16:0]        den_abs;
  logic [16:0]               trial;
  logic                      trial_ge;
  logic signed [33:0]        q_s;
  logic signed [34:0]        p_full;
  logic signed [17:0]        pos_sat;
  logic signed [18:0]        err_full;
  logic signed [18:0]        derr;
  logic signed [32:0]        sum_full;
  logic signed [31:0]        sum_sat;
  logic                      hold;
  logic signed [TOT_W-1:0]   bias_sh;
  logic signed [TOT_W-1:0]   total;
  logic [15:0]               thrust;
  logic                      out_stall;

  assign s_m  = in_tdata & CODE_MASK;
  assign lo_m = cfg.low_code & CODE_MASK;
  assign hi_m = cfg.high_code & CODE_MASK;

  always_comb begin
    unique case (ctrl.op)
      OP_MUL_P: mul_a = $signed({1'b0, cfg.kp});
      OP_MUL_D: mul_a = $signed({1'b0, cfg.kd_scaled});
      OP_MUL_I: mul_a = $signed({1'b0, cfg.ki_scaled});
      default:  mul_a = $signed({1'b0, cfg.travel_length});
    endcase
    unique case (ctrl.op)
      OP_MUL_P: mul_b = {{15{err_r[17]}}, err_r};
      OP_MUL_D: mul_b = {{14{derr_r[18]}}, derr_r};
      OP_MUL_I: mul_b = {error_sum_r[31], error_sum_r};
      default:  mul_b = {{16{diff_r[16]}}, diff_r};
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign num_abs  = prod_r[33] ? -$signed(prod_r[33:0]) : $signed(prod_r[33:0]);
  assign den_abs  = den_r[16] ? -den_r : den_r;
  assign trial    = {rem_r, quo_r[31]};
  assign trial_ge = (trial >= {1'b0, den_mag_r});

  always_comb begin
    q_s    = neg_r ? -$signed({2'b00, quo_r}) : $signed({2'b00, quo_r});
    p_full = $signed({19'd0, cfg.travel_length}) - {q_s[33], q_s};
    if (fault_r) begin
      pos_sat = '0;
    end else if (p_full < POS_MIN) begin
      pos_sat = 18'(POS_MIN);
    end else if (p_full > POS_MAX) begin
      pos_sat = 18'(POS_MAX);
    end else begin
      pos_sat = p_full[17:0];
    end
  end

  assign err_full = $signed({3'b000, cfg.setpoint}) - {pos_r[17], pos_r};
  assign derr     = {err_r[17], err_r} - {last_error_r[17], last_error_r};

  always_comb begin
    sum_full = {error_sum_r[31], error_sum_r} + {{15{err_r[17]}}, err_r};
    if (sum_full[32] != sum_full[31]) begin
      sum_sat = sum_full[32] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_sat = sum_full[31:0];
    end
  end

  assign hold    = !(pd_r < WIN_LIM);
  assign bias_sh = $signed(TOT_W'(cfg.bias) << GAIN_FRAC_BITS);
  assign total   = bias_sh + TOT_W'(pd_r) + TOT_W'(prod_r);

  always_comb begin
    if (total_r >= THR_HI_FULL) begin
      thrust = 16'(THRUST_HI * 256);
    end else if (total_r < THR_LO_FULL) begin
      thrust = 16'(THRUST_LO * 256);
    end else begin
      thrust = total_r[GAIN_FRAC_BITS +: 16];
    end
  end

  assign out_stall      = out_tvalid_r && !out_tready;
  assign stat.out_stall = out_stall;
  assign stat.div_last  = (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1));
  assign out_tvalid     = out_tvalid_r;
  assign out_tdata      = out_tdata_r;

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      OP_LOAD: begin
        diff_r  <= $signed({1'b0, s_m}) - $signed({1'b0, lo_m});
        den_r   <= $signed({1'b0, hi_m}) - $signed({1'b0, lo_m});
        fault_r <= (hi_m == lo_m);
      end
      OP_MUL_POS: prod_r <= mul_p;
      OP_DIV_INIT: begin
        quo_r     <= num_abs[31:0];
        den_mag_r <= den_abs[15:0];
        neg_r     <= prod_r[33] ^ den_r[16];
        rem_r     <= '0;
        div_cnt_r <= '0;
      end
      OP_DIV_STEP: begin
        rem_r     <= trial_ge ? 16'(trial - {1'b0, den_mag_r}) : trial[15:0];
        quo_r     <= {quo_r[30:0], trial_ge};
        div_cnt_r <= div_cnt_r + 1'b1;
      end
      OP_POS: pos_r <= pos_sat;
      OP_ERR: err_r <= err_full[17:0];
      OP_MUL_P: begin
        prod_r <= mul_p;
        derr_r <= derr;
      end
      OP_MUL_D: begin
        prod_r  <= mul_p;
        pterm_r <= prod_r[34:0];
      end
      OP_PD: pd_r <= $signed(pterm_r) + $signed(prod_r[35:0]);
      OP_MUL_I: prod_r <= mul_p;
      OP_TOTAL: total_r <= total;
      OP_OUT: begin
        if (!out_stall) begin
          out_tdata_r <= {4'b0000, fault_r, hold_r, pos_r, thrust};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_error_r <= '0;
      error_sum_r  <= '0;
      hold_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (ctrl.op == OP_SUM) begin
        hold_r       <= hold;
        last_error_r <= err_r;
        if (!hold) begin
          error_sum_r <= sum_sat;
        end
      end
      if (ctrl.op == OP_OUT && !out_stall) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/core/position_pid_thrust_controller.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// position_pid_thrust_controller
// Maps a potentiometer sample to a position and runs a PID law with
// conditional integration to produce a clamped thrust command.
//
// Channels: in_* carries one sample per transaction; out_* returns one
// result per sample; cfg_* writes the eight gain and calibration registers
// and is always ready. Write configuration only while no sample is in work.
// Timing: a new sample is taken only once the previous one has run through
// all states and its result has entered the output register. The time
// is set by the 32-step bit-serial divider of the position mapping and the
// single shared multiplier used in turn for the mapping, P, D and I terms.
// Reset (rst_n low, synchronous) restores the register defaults and clears
// the integral and the stored previous error.
// A stalled receiver holds the result in the output register; the next
// sample is still accepted and processed, and its result waits until the
// register is free.
// ---------------------------------------------------------------------------
module position_pid_thrust_controller #(
  parameter int SAMPLE_BITS    = 16,
  parameter int GAIN_FRAC_BITS = 12
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [15:0]                    in_tdata,   // [15:0] sample
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [15:0] thrust, [33:16] position, [34] windup_hold, [35] span_fault
  output logic [39:0]                    out_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pptc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_data
);
  import pptc_pkg::*;

  cfg_t     cfg;
  dp_ctrl_t ctrl;
  dp_stat_t stat;

  pptc_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pptc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  pptc_dp #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .ctrl       (ctrl),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
